FILE: src/itoc_pkg.sv
`default_nettype none
package itoc_pkg;

   typedef enum logic [1:0] {
      ST_TIMED   = 2'd0,
      ST_NO_TRIP = 2'd1,
      ST_INSTANT = 2'd2,
      ST_SAT     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EXP_FRAC = 2'd0,
      EXP_ONE  = 2'd1,
      EXP_TWO  = 2'd2
   } exp_type;

   localparam logic [2:0] CV_IEC_SI   = 3'd0;
   localparam logic [2:0] CV_IEC_VI   = 3'd1;
   localparam logic [2:0] CV_IEC_EI   = 3'd2;
   localparam logic [2:0] CV_IEC_LTI  = 3'd3;
   localparam logic [2:0] CV_IEEE_MI  = 3'd4;
   localparam logic [2:0] CV_IEEE_VI  = 3'd5;
   localparam logic [2:0] CV_IEEE_EI  = 3'd6;
   localparam logic [2:0] CV_LAST     = CV_IEEE_EI;

   localparam logic [1:0] REG_CURVE = 2'd0;
   localparam logic [1:0] REG_TM    = 2'd1;
   localparam logic [1:0] REG_INST  = 2'd2;

   localparam logic [23:0] ONE_Q16    = 24'd65536;
   localparam logic [26:0] FRAC02_Q32 = 27'd85899346;
   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [17:0] ROUND_HALF = 18'd131072;
   localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

   localparam int POW_LAT  = 63;
   localparam int BACK_LAT = 54;

   typedef struct packed {
      logic [23:0] m;
      status_type  status;
      logic [2:0]  curve;
   } item_type;

   function automatic logic [38:0] curve_k(input logic [2:0] c);
      logic [38:0] k;
      unique case (c)
         CV_IEC_SI:  k = 39'd601295421;
         CV_IEC_VI:  k = 39'd57982058496;
         CV_IEC_EI:  k = 39'd343597383680;
         CV_IEC_LTI: k = 39'd515396075520;
         CV_IEEE_MI: k = 39'd221190816;
         CV_IEEE_VI: k = 39'd84224308675;
         CV_IEEE_EI: k = 39'd121118077747;
         default:    k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [22:0] curve_b(input logic [2:0] c);
      logic [22:0] b;
      unique case (c)
         CV_IEEE_MI: b = 23'd1912603;
         CV_IEEE_VI: b = 23'd8237613;
         CV_IEEE_EI: b = 23'd2041787;
         default:    b = '0;
      endcase
      return b;
   endfunction

   function automatic exp_type curve_exp(input logic [2:0] c);
      exp_type e;
      unique case (c)
         CV_IEC_VI, CV_IEC_LTI:             e = EXP_ONE;
         CV_IEC_EI, CV_IEEE_VI, CV_IEEE_EI: e = EXP_TWO;
         default:                           e = EXP_FRAC;
      endcase
      return e;
   endfunction

   // floor(2^32 / n) for the series divisors
   function automatic logic [31:0] horner_recip(input logic [3:0] n);
      logic [31:0] r;
      unique case (n)
         4'd2:    r = 32'd2147483648;
         4'd3:    r = 32'd1431655765;
         4'd4:    r = 32'd1073741824;
         4'd5:    r = 32'd858993459;
         4'd6:    r = 32'd715827882;
         4'd7:    r = 32'd613566756;
         4'd8:    r = 32'd536870912;
         4'd9:    r = 32'd477218588;
         4'd10:   r = 32'd429496729;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/inverse_time_overcurrent_trip_top.sv
// Path: an accepted beat reaches its result through the queue, the 63-stage power unit
// and the 54-stage divide and scale unit, and waits in the queue while the back end is stalled.
// Throughput: one beat per cycle unless stalled; the back pipeline advances
// whenever its output register is empty or popped.
// Reset: synchronous, active high; clears the queue and all stage valid bits and
// loads the curve, time multiplier and instantaneous multiple with their defaults.
`default_nettype none
module inverse_time_overcurrent_trip_top import itoc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [23:0] req_current_multiple,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_trip_seconds,
   output logic [1:0]  rsp_trip_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0]  curve_ff;
   logic [15:0] tm_ff;
   logic [23:0] inst_ff;
   logic        csr_wr;

   item_type    front_item;
   item_type    head_item;
   logic        q_empty;
   logic        adv;
   logic        pow_valid;
   item_type    pow_item;
   logic [31:0] pow_d;
   logic        back_valid;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_ff <= CV_IEC_SI;
         tm_ff    <= 16'd1024;
         inst_ff  <= 24'd1310720;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_CURVE: curve_ff <= pwdata[2:0];
            REG_TM:    tm_ff    <= pwdata[15:0];
            REG_INST:  inst_ff  <= pwdata[23:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_CURVE: prdata = {29'b0, curve_ff};
         REG_TM:    prdata = {16'b0, tm_ff};
         REG_INST:  prdata = {8'b0, inst_ff};
         default:   prdata = '0;
      endcase
   end

   itoc_front u_front (
      .req_current_multiple (req_current_multiple),
      .curve_select         (curve_ff),
      .instant_multiple     (inst_ff),
      .item                 (front_item)
   );

   assign adv = !back_valid || pop;

   itoc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_req  (push),
      .wr_item (front_item),
      .full    (full),
      .rd_req  (adv),
      .empty   (q_empty),
      .rd_item (head_item)
   );

   itoc_pow u_pow (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (!q_empty),
      .in_item   (head_item),
      .out_valid (pow_valid),
      .out_item  (pow_item),
      .d_out     (pow_d)
   );

   itoc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (pow_valid),
      .in_item         (pow_item),
      .d_frac          (pow_d),
      .time_multiplier (tm_ff),
      .out_valid       (back_valid),
      .trip_seconds    (rsp_trip_seconds),
      .trip_status     (rsp_trip_status)
   );

   assign empty = !back_valid;

endmodule
`default_nettype wire

FILE: src/itoc_front.sv
`default_nettype none
module itoc_front import itoc_pkg::*; (
   input  logic [23:0] req_current_multiple,
   input  logic [2:0]  curve_select,
   input  logic [23:0] instant_multiple,
   output item_type    item
);

   always_comb begin
      item.m     = req_current_multiple;
      item.curve = curve_select;
      priority if (req_current_multiple <= ONE_Q16 || curve_select > CV_LAST) begin
         item.status = ST_NO_TRIP;
      end else if (req_current_multiple >= instant_multiple) begin
         item.status = ST_INSTANT;
      end else begin
         item.status = ST_TIMED;
      end
   end

endmodule
`default_nettype wire

FILE: src/itoc_queue.sv
`default_nettype none
module itoc_queue import itoc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_req,
   input  item_type wr_item,
   output logic     full,
   input  logic     rd_req,
   output logic     empty,
   output item_type rd_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [0:DEPTH-1];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            wr_en, rd_en;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_en   = wr_req && !full;
   assign rd_en   = rd_req && !empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count above depth");
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");
   assert property (@(posedge clock) disable iff (reset)
      (rd_en && !wr_en) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a read");

endmodule
`default_nettype wire

FILE: src/itoc_pow.sv
`default_nettype none
module itoc_pow import itoc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  item_type    in_item,
   output logic        out_valid,
   output item_type    out_item,
   output logic [31:0] d_out
);

   localparam int SQ_N = 32;
   localparam int H_N  = 9;

   logic [POW_LAT-1:0] vld_ff;
   item_type           itm_ff [0:POW_LAT-1];

   logic [2:0]  norm_p;
   logic [31:0] norm_y;

   logic [31:0] sq_y_ff [0:SQ_N];
   logic [31:0] sq_f_ff [0:SQ_N];
   logic [2:0]  sq_p_ff [0:SQ_N];
   logic [31:0] sq_y_in [1:SQ_N];
   logic [31:0] sq_f_in [1:SQ_N];
   logic [63:0] sq_prod [1:SQ_N];

   logic [34:0] lval;
   logic [61:0] x_prod, t_prod, fin_prod;
   logic [29:0] x_ff;
   logic [28:0] t_ff;

   logic [29:0] ha_v_ff  [0:H_N-1];
   logic [28:0] ha_t_ff  [0:H_N-1];
   logic [29:0] hb_qe_ff [0:H_N-1];
   logic [29:0] hb_v_ff  [0:H_N-1];
   logic [28:0] hb_t_ff  [0:H_N-1];
   logic [32:0] hc_acc_ff[0:H_N-1];
   logic [28:0] hc_t_ff  [0:H_N-1];
   logic [61:0] ha_prod  [0:H_N-1];
   logic [61:0] hb_prod  [0:H_N-1];
   logic [33:0] hc_rem   [0:H_N-1];
   logic [32:0] hc_acc_in[0:H_N-1];
   logic [31:0] d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[POW_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm_ff[0] <= in_item;
         for (int i = 1; i < POW_LAT; i++) begin
            itm_ff[i] <= itm_ff[i-1];
         end
      end
   end

   // normalize M to Q1.31
   always_comb begin
      norm_p = '0;
      for (int b = 1; b < 8; b++) begin
         if (in_item.m[16+b]) begin
            norm_p = 3'(b);
         end
      end
      norm_y = {8'b0, in_item.m} << (4'd15 - {1'b0, norm_p});
   end

   always_comb begin
      for (int j = 1; j <= SQ_N; j++) begin
         sq_prod[j] = 64'(sq_y_ff[j-1]) * 64'(sq_y_ff[j-1]);
         sq_f_in[j] = sq_f_ff[j-1];
         if (sq_prod[j][63]) begin
            sq_y_in[j] = sq_prod[j][63:32];
            sq_f_in[j][SQ_N-j] = 1'b1;
         end else begin
            sq_y_in[j] = sq_prod[j][62:31];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_y_ff[0] <= norm_y;
         sq_f_ff[0] <= '0;
         sq_p_ff[0] <= norm_p;
         for (int j = 1; j <= SQ_N; j++) begin
            sq_y_ff[j] <= sq_y_in[j];
            sq_f_ff[j] <= sq_f_in[j];
            sq_p_ff[j] <= sq_p_ff[j-1];
         end
      end
   end

   assign lval   = {sq_p_ff[SQ_N], sq_f_ff[SQ_N]};
   assign x_prod = 62'(lval) * 62'(FRAC02_Q32);
   assign t_prod = 62'(x_ff) * 62'(LN2_Q32);

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_prod[61:32];
         t_ff <= t_prod[60:32];
      end
   end

   always_comb begin
      for (int j = 0; j < H_N; j++) begin
         if (j == 0) begin
            ha_prod[j] = 62'(ONE_Q32) * 62'(t_ff);
         end else begin
            ha_prod[j] = 62'(hc_acc_ff[j-1]) * 62'(hc_t_ff[j-1]);
         end
         hb_prod[j] = 62'(ha_v_ff[j]) * 62'(horner_recip(4'(10 - j)));
         hc_rem[j]  = 34'(hb_v_ff[j]) - 34'(hb_qe_ff[j]) * 34'(10 - j);
         hc_acc_in[j] = ONE_Q32 + 33'(hb_qe_ff[j])
                      + 33'(hc_rem[j] >= 34'(10 - j));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < H_N; j++) begin
            ha_v_ff[j]   <= ha_prod[j][61:32];
            ha_t_ff[j]   <= (j == 0) ? t_ff : hc_t_ff[j-1];
            hb_qe_ff[j]  <= hb_prod[j][61:32];
            hb_v_ff[j]   <= ha_v_ff[j];
            hb_t_ff[j]   <= ha_t_ff[j];
            hc_acc_ff[j] <= hc_acc_in[j];
            hc_t_ff[j]   <= hb_t_ff[j];
         end
      end
   end

   assign fin_prod = 62'(hc_acc_ff[H_N-1]) * 62'(hc_t_ff[H_N-1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= {2'b0, fin_prod[61:32]};
      end
   end

   assign out_valid = vld_ff[POW_LAT-1];
   assign out_item  = itm_ff[POW_LAT-1];
   assign d_out     = d_ff;

endmodule
`default_nettype wire

FILE: src/itoc_back.sv
`default_nettype none
module itoc_back import itoc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  item_type    in_item,
   input  logic [31:0] d_frac,
   input  logic [15:0] time_multiplier,
   output logic        out_valid,
   output logic [31:0] trip_seconds,
   output logic [1:0]  trip_status
);

   localparam int DIV_N = 50;

   logic [BACK_LAT-1:0] vld_ff;
   item_type            itm_ff [0:BACK_LAT-2];

   logic [47:0] d_sel;
   logic [47:0] s1_d_ff;
   logic [38:0] s1_k_ff;
   logic [22:0] s1_b_ff;
   logic [47:0] s2_d;
   logic [12:0] s2_hi;
   logic        s2_ovf;

   logic [47:0] dv_ff  [0:DIV_N];
   logic [47:0] rem_ff [0:DIV_N];
   logic [49:0] nl_ff  [0:DIV_N];
   logic [49:0] q_ff   [0:DIV_N];
   logic        ovf_ff [0:DIV_N];
   logic [22:0] b_ff   [0:DIV_N];
   logic [48:0] div_sh [1:DIV_N];
   logic [48:0] div_df [1:DIV_N];

   logic [50:0] qsum;
   logic [66:0] prod_ff;
   logic        f1_ovf_ff;
   logic [66:0] rounded;
   status_type  st_f;
   logic [31:0] sec_ff;
   status_type  stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[BACK_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm_ff[0] <= in_item;
         for (int i = 1; i < BACK_LAT - 1; i++) begin
            itm_ff[i] <= itm_ff[i-1];
         end
      end
   end

   always_comb begin
      unique case (curve_exp(in_item.curve))
         EXP_ONE: d_sel = 48'({in_item.m - ONE_Q16, 16'b0});
         EXP_TWO: d_sel = 48'(in_item.m) * 48'(in_item.m) - 48'h1_0000_0000;
         default: d_sel = 48'(d_frac);
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_d_ff <= d_sel;
         s1_k_ff <= curve_k(in_item.curve);
         s1_b_ff <= curve_b(in_item.curve);
      end
   end

   // quotient of 2^50 or more saturates timed beats unless the time multiplier is zero
   assign s2_d   = (s1_d_ff == '0) ? 48'd1 : s1_d_ff;
   assign s2_hi  = s1_k_ff[38:26];
   assign s2_ovf = (48'(s2_hi) >= s2_d);

   always_comb begin
      for (int k = 1; k <= DIV_N; k++) begin
         div_sh[k] = {rem_ff[k-1], nl_ff[k-1][49]};
         div_df[k] = div_sh[k] - {1'b0, dv_ff[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0]  <= s2_d;
         rem_ff[0] <= s2_ovf ? '0 : 48'(s2_hi);
         nl_ff[0]  <= {s1_k_ff[25:0], 24'b0};
         q_ff[0]   <= '0;
         ovf_ff[0] <= s2_ovf;
         b_ff[0]   <= s1_b_ff;
         for (int k = 1; k <= DIV_N; k++) begin
            dv_ff[k]  <= dv_ff[k-1];
            nl_ff[k]  <= {nl_ff[k-1][48:0], 1'b0};
            ovf_ff[k] <= ovf_ff[k-1];
            b_ff[k]   <= b_ff[k-1];
            if (div_sh[k] >= {1'b0, dv_ff[k-1]}) begin
               rem_ff[k] <= div_df[k][47:0];
               q_ff[k]   <= {q_ff[k-1][48:0], 1'b1};
            end else begin
               rem_ff[k] <= div_sh[k][47:0];
               q_ff[k]   <= {q_ff[k-1][48:0], 1'b0};
            end
         end
      end
   end

   assign qsum = 51'(q_ff[DIV_N]) + 51'(b_ff[DIV_N]);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= 67'(qsum) * 67'(time_multiplier);
         f1_ovf_ff <= ovf_ff[DIV_N];
      end
   end

   assign rounded = prod_ff + 67'(ROUND_HALF);
   assign st_f    = itm_ff[BACK_LAT-2].status;

   always_ff @(posedge clock) begin
      if (adv) begin
         priority if (st_f != ST_TIMED) begin
            sec_ff  <= '0;
            stat_ff <= st_f;
         end else if (time_multiplier == '0) begin
            sec_ff  <= '0;
            stat_ff <= ST_TIMED;
         end else if (f1_ovf_ff || rounded[66:50] != '0) begin
            sec_ff  <= '1;
            stat_ff <= ST_SAT;
         end else begin
            sec_ff  <= rounded[49:18];
            stat_ff <= ST_TIMED;
         end
      end
   end

   assign out_valid    = vld_ff[BACK_LAT-1];
   assign trip_seconds = sec_ff;
   assign trip_status  = stat_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && stat_ff == ST_SAT) |-> sec_ff == 32'hFFFF_FFFF)
      else $error("saturated beat without all-ones time");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && (stat_ff == ST_NO_TRIP || stat_ff == ST_INSTANT)) |-> sec_ff == '0)
      else $error("untimed beat with nonzero time");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !adv) |=> out_valid)
      else $error("stalled result beat dropped");

endmodule
`default_nettype wire
